// ===== rtl/clocked_serial_packet_sniffer_defines.svh =====
// Assertion helpers shared by the sniffer RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef CLOCKED_SERIAL_PACKET_SNIFFER_DEFINES_SVH
`define CLOCKED_SERIAL_PACKET_SNIFFER_DEFINES_SVH

// Same-cycle implication
`define CSS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/css_pkg.sv =====
package css_pkg;

   // Configuration register indexes
   localparam logic CSR_IDLE_TICKS   = 1'b0;
   localparam logic CSR_PACKET_BYTES = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // Reset values of the configuration registers
   localparam logic [15:0] IDLE_TICKS_RESET   = 16'd550;
   localparam logic [4:0]  PACKET_BYTES_RESET = 5'd6;

   // Longest packet supported
   localparam logic [4:0]  PACKET_MAX = 5'd16;

   // One received byte
   typedef struct packed {
      logic [7:0] byte_value;
      logic [3:0] byte_index;
      logic       last_of_packet;
   } css_result_type;

endpackage

// ===== rtl/css_core.sv =====
`include "clocked_serial_packet_sniffer_defines.svh"

module css_core
   import css_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   clock_level,
   input  logic                   data_level,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output logic                   produce,
   output css_result_type         result
);

   logic [15:0] idle_ticks_ff;
   logic [4:0]  packet_bytes_ff;

   logic        synced_ff,     synced_in;
   logic [15:0] idle_count_ff, idle_count_in;
   logic        prev_clock_ff, prev_clock_in;
   logic [7:0]  shift_reg_ff,  shift_reg_in;
   logic [2:0]  bit_count_ff,  bit_count_in;
   logic [3:0]  byte_count_ff, byte_count_in;

   logic [4:0]  eff_length;
   logic [4:0]  next_count;
   logic [7:0]  shifted;
   logic        rise;
   logic        last;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff   <= IDLE_TICKS_RESET;
         packet_bytes_ff <= PACKET_BYTES_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IDLE_TICKS:   idle_ticks_ff   <= csr_write_data;
            CSR_PACKET_BYTES: packet_bytes_ff <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // Packet length clamped to 1..16
   always_comb begin
      if (packet_bytes_ff == 5'd0) begin
         eff_length = 5'd1;
      end else if (packet_bytes_ff > PACKET_MAX) begin
         eff_length = PACKET_MAX;
      end else begin
         eff_length = packet_bytes_ff;
      end
   end

   assign rise       = clock_level && !prev_clock_ff;
   assign shifted    = {shift_reg_ff[6:0], data_level};
   assign next_count = {1'b0, byte_count_ff} + 5'd1;
   assign last       = (next_count >= eff_length);

   // Sync search and bit assembly
   always_comb begin
      synced_in     = synced_ff;
      idle_count_in = idle_count_ff;
      shift_reg_in  = shift_reg_ff;
      bit_count_in  = bit_count_ff;
      byte_count_in = byte_count_ff;
      prev_clock_in = clock_level;
      produce       = 1'b0;
      if (!synced_ff) begin
         if (clock_level) begin
            idle_count_in = '0;
         end else if (idle_count_ff < idle_ticks_ff) begin
            idle_count_in = idle_count_ff + 16'd1;
         end
         if (idle_count_in >= idle_ticks_ff) begin
            synced_in = 1'b1;
         end
      end else if (rise) begin
         if (bit_count_ff == 3'd7) begin
            produce       = 1'b1;
            byte_count_in = last ? 4'd0 : next_count[3:0];
            shift_reg_in  = '0;
            bit_count_in  = '0;
         end else begin
            shift_reg_in  = shifted;
            bit_count_in  = bit_count_ff + 3'd1;
         end
      end
   end

   assign result.byte_value     = shifted;
   assign result.byte_index     = byte_count_ff;
   assign result.last_of_packet = last;

   // Receiver state, updated per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff     <= 1'b0;
         idle_count_ff <= '0;
         prev_clock_ff <= 1'b1;
         shift_reg_ff  <= '0;
         bit_count_ff  <= '0;
         byte_count_ff <= '0;
      end else if (accept) begin
         synced_ff     <= synced_in;
         idle_count_ff <= idle_count_in;
         prev_clock_ff <= prev_clock_in;
         shift_reg_ff  <= shift_reg_in;
         bit_count_ff  <= bit_count_in;
         byte_count_ff <= byte_count_in;
      end
   end

   `CSS_ASSERT_IMPL(a_bits_only_synced, bit_count_ff != 3'd0, synced_ff, "bits without sync")
   `CSS_ASSERT_IMPL(a_shift_clear_unsynced, !synced_ff, shift_reg_ff == 8'd0, "shift not clear")
   `CSS_ASSERT_IMPL(a_last_at_max, produce && byte_count_ff == 4'd15, last, "index 15 not last")

endmodule

// ===== rtl/css_out_reg.sv =====
`include "clocked_serial_packet_sniffer_defines.svh"

module css_out_reg
   import css_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  css_result_type load_data,
   input  logic           rsp_stall,
   output logic           busy,
   output logic           rsp_valid,
   output css_result_type rsp_data
);

   logic           valid_ff, valid_in;
   css_result_type data_ff;

   // Slot is blocked only when full and the consumer stalls
   assign busy = valid_ff && rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `CSS_ASSERT_IMPL(a_no_overwrite, load, !busy, "result overwritten while stalled")
   `CSS_ASSERT_NEXT(a_load_shows, load, valid_ff, "loaded result not shown")
   `CSS_ASSERT_NEXT(a_drain, valid_ff && !rsp_stall && !load, !valid_ff, "taken result repeated")

endmodule

// ===== rtl/clocked_serial_packet_sniffer.sv =====
// A byte appears on rsp_valid in the cycle after the item with its eighth bit is accepted.
// Throughput: one item per cycle; req_stall rises only while a held byte is stalled on rsp_stall.
// Sync search, edge detection and bit assembly all finish in the accept cycle.
// Reset (synchronous, active high): unsynced, counters clear, idle_ticks 550, packet_bytes 6,
// result register empty.
module clocked_serial_packet_sniffer
   import css_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_clock_level,
   input  logic                   req_data_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_byte_value,
   output logic [3:0]             rsp_byte_index,
   output logic                   rsp_last_of_packet,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic           accept;
   logic           produce;
   logic           busy;
   css_result_type result;
   css_result_type rsp_data;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   css_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .clock_level      (req_clock_level),
      .data_level       (req_data_level),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .produce          (produce),
      .result           (result)
   );

   css_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && produce),
      .load_data (result),
      .rsp_stall (rsp_stall),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_byte_value     = rsp_data.byte_value;
   assign rsp_byte_index     = rsp_data.byte_index;
   assign rsp_last_of_packet = rsp_data.last_of_packet;

endmodule

// ===== test/clocked_serial_packet_sniffer_test.sv =====
module clocked_serial_packet_sniffer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import css_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS   = 185;
   localparam int HOLD_CYCLES   = 400;

   // One sample of the external serial lines
   typedef struct packed {
      logic clock_level;
      logic data_level;
   } pin_sample_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_clock_level = 1'b0;
   logic                   req_data_level = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_byte_value;
   logic [3:0]             rsp_byte_index;
   logic                   rsp_last_of_packet;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Pending samples and bytes the decoder should still emit
   pin_sample_type pin_samples[$];
   css_result_type expected_bytes[$];

   // Decoder copy: configuration and receive state
   logic [15:0] idle_limit  = IDLE_TICKS_RESET;
   logic [4:0]  pkt_len_cfg = PACKET_BYTES_RESET;
   logic        in_sync     = 1'b0;
   logic [15:0] quiet_ticks = '0;
   logic        last_clock  = 1'b1;
   logic [7:0]  shift_bits  = '0;
   logic [2:0]  bit_pos     = '0;
   logic [3:0]  byte_pos    = '0;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_trigger  = 0;
   int  hold_seen     = 0;
   int  hold_left     = 0;
   int  samples_queued = 0;
   int  items_accepted = 0;
   int  bytes_checked  = 0;
   int  fail_count     = 0;
   int  cycle_count    = 0;
   logic sample_taken  = 1'b0;

   clocked_serial_packet_sniffer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_clock_level    (req_clock_level),
      .req_data_level     (req_data_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last_of_packet (rsp_last_of_packet),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      fail_count++;
   endtask

   // Advance the decoder by one accepted sample; queue a byte when one completes
   task automatic decode_sample(input logic clk, input logic dat);
      css_result_type got;
      logic [7:0]     shifted;
      int             len;
      if (!in_sync) begin
         if (clk)
            quiet_ticks = '0;
         else if (quiet_ticks < idle_limit)
            quiet_ticks = quiet_ticks + 16'd1;
         if (quiet_ticks >= idle_limit)
            in_sync = 1'b1;
      end else if (clk && !last_clock) begin
         shifted = {shift_bits[6:0], dat};
         if (bit_pos == 3'd7) begin
            // out-of-range lengths clamp to 1..16
            len = (pkt_len_cfg == 5'd0) ? 1 :
                  (pkt_len_cfg > PACKET_MAX) ? int'(PACKET_MAX) : int'(pkt_len_cfg);
            got.byte_value     = shifted;
            got.byte_index     = byte_pos;
            got.last_of_packet = (int'(byte_pos) + 1 >= len);
            expected_bytes.push_back(got);
            byte_pos   = got.last_of_packet ? 4'd0 : byte_pos + 4'd1;
            shift_bits = '0;
            bit_pos    = '0;
         end else begin
            shift_bits = shifted;
            bit_pos    = bit_pos + 3'd1;
         end
      end
      last_clock = clk;
   endtask

   // Driver: next sample goes out once the current one is taken
   always @(negedge clock) begin
      pin_sample_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || sample_taken) begin
         if (pin_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            s = pin_samples.pop_front();
            req_valid       <= 1'b1;
            req_clock_level <= s.clock_level;
            req_data_level  <= s.data_level;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: long hold-off on request, random otherwise
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: predict on accepted samples, check accepted bytes
   always @(posedge clock) begin
      css_result_type want;
      cycle_count++;
      if (!reset && req_valid && !req_stall) begin
         decode_sample(req_clock_level, req_data_level);
         items_accepted++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h index %0d", rsp_byte_value,
                                      rsp_byte_index));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_byte_value !== want.byte_value)
               report_mismatch($sformatf("byte_value %02h, expected %02h", rsp_byte_value,
                                         want.byte_value));
            if (rsp_byte_index !== want.byte_index)
               report_mismatch($sformatf("byte_index %0d, expected %0d", rsp_byte_index,
                                         want.byte_index));
            if (rsp_last_of_packet !== want.last_of_packet)
               report_mismatch($sformatf("last_of_packet %0b, expected %0b",
                                         rsp_last_of_packet, want.last_of_packet));
            bytes_checked++;
         end
      end
      sample_taken <= !reset && req_valid && !req_stall;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d bytes outstanding", cycle_count,
                  expected_bytes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_sample(input logic clk, input logic dat);
      pin_samples.push_back({clk, dat});
      samples_queued++;
   endtask

   // One byte, MSB first; tight framing uses one low and one high sample per bit
   task automatic queue_byte(input logic [7:0] value, input bit tight);
      int lows;
      int highs;
      for (int b = 7; b >= 0; b--) begin
         lows  = tight ? 1 : $urandom_range(2, 1);
         highs = tight ? 1 : $urandom_range(2, 1);
         repeat (lows) queue_sample(1'b0, 1'($urandom_range(1)));
         queue_sample(1'b1, value[b]);
         repeat (highs - 1) queue_sample(1'b1, 1'($urandom_range(1)));
      end
   endtask

   // Wait until every sample is taken and every byte seen, then let the pipe drain
   task automatic settle();
      do
         @(negedge clock);
      while (pin_samples.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == CSR_IDLE_TICKS)
         idle_limit = value;
      else
         pkt_len_cfg = value[4:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly framed bytes with random content, some line noise in between
   task automatic run_phase(input int count);
      int         start;
      logic [7:0] value;
      start = samples_queued;
      while (samples_queued - start < count) begin
         if ($urandom_range(99) < 85) begin
            case ($urandom_range(9))
               0: value = 8'h00;
               1: value = 8'hFF;
               default: value = 8'($urandom);
            endcase
            queue_byte(value, 1'b0);
         end else begin
            repeat ($urandom_range(12, 1))
               queue_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
      settle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 35;
      recv_idle_pct = 61;

      // Unsynced: long idle limit, quiet run broken by one high clock
      write_csr(CSR_IDLE_TICKS, 16'hFFFF);
      write_csr(CSR_PACKET_BYTES, 16'd16);
      repeat (4) queue_sample(1'b0, 1'($urandom_range(1)));
      queue_sample(1'b1, 1'($urandom_range(1)));
      repeat (3) queue_sample(1'b0, 1'($urandom_range(1)));
      settle();

      // Zero idle limit syncs on the next sample, even with clock high
      write_csr(CSR_IDLE_TICKS, 16'h0000);
      queue_sample(1'b1, 1'b1);
      queue_byte(8'hA5, 1'b1);
      repeat (10) queue_byte(8'($urandom), 1'b1);
      settle();

      // Shorten the packet while it is partly received
      write_csr(CSR_PACKET_BYTES, 16'd3);
      run_phase(PHASE_ITEMS);
      write_csr(CSR_PACKET_BYTES, 16'd0);
      run_phase(PHASE_ITEMS);
      write_csr(CSR_PACKET_BYTES, 16'd31);
      run_phase(PHASE_ITEMS);

      send_idle_pct = 61;
      recv_idle_pct = 35;
      write_csr(CSR_PACKET_BYTES, 16'd17);
      write_csr(CSR_IDLE_TICKS, 16'($urandom));
      run_phase(PHASE_ITEMS);
      write_csr(CSR_PACKET_BYTES, 16'd1);
      run_phase(PHASE_ITEMS);
      write_csr(CSR_PACKET_BYTES, 16'($urandom_range(16, 1)));
      run_phase(PHASE_ITEMS);

      // No idling; receiver holds off long enough for the input to back up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_PACKET_BYTES, 16'd16);
      hold_trigger++;
      run_phase(PHASE_ITEMS);
      // upper write bits are not part of the packet length
      write_csr(CSR_PACKET_BYTES, {11'($urandom), 5'($urandom_range(16, 1))});
      run_phase(PHASE_ITEMS);
      write_csr(CSR_PACKET_BYTES, 16'd2);
      run_phase(PHASE_ITEMS);

      $display("Sent %0d line samples, checked %0d received bytes", items_accepted,
               bytes_checked);
      $display("Packet lengths 0 to 31 incl. mid-packet shortening, idle limits 0 and 65535");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
